>>> design/itr_pkg.sv
`default_nettype none
package itr_pkg;

	localparam int NUM_W      = 31;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 7;
	localparam int MAX_DIGITS = 32;
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int STEP_W     = $clog2(NUM_W);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] DEC_LIMIT = RADIX_W'(9);
	localparam logic [RADIX_W-1:0] ALPHA_OFS = RADIX_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  CHAR_A    = CHAR_W'(8'h41);

	typedef struct packed {
		logic [NUM_W-1:0]   number;
		logic [RADIX_W-1:0] radix;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
		logic              empty_res;
	} dig_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   dividend;
		logic [RADIX_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic               done;
		logic [NUM_W-1:0]   quotient;
		logic [RADIX_W-1:0] remainder;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} state_t;

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
		logic [RADIX_W-1:0] r;
		r = raw;
		if (raw < RADIX_MIN) r = RADIX_MIN;
		if (raw > RADIX_MAX) r = RADIX_MAX;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] v);
		logic [CHAR_W-1:0] c;
		if (v > DEC_LIMIT) begin
			c = CHAR_W'(v - ALPHA_OFS) + CHAR_A;
		end else begin
			c = CHAR_W'(v) + CHAR_ZERO;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> design/integer_to_radix_digits.sv
`default_nettype none
// Converts a 31-bit unsigned number to ASCII digits in radix 2..36 (radix saturates
// into that range), most significant digit first, one word per digit, last digit marked;
// a zero number gives one word flagged empty and last. Items are taken one at a time: a
// new word is accepted only when the block is idle and its output register is empty.
// Each digit comes from the bit-serial divider (one quotient bit per cycle, restarted on
// the quotient until it is zero), whose remainders go into the digit store; the digits are
// then read back from the store and emitted, and output stalls hold the emission.
module integer_to_radix_digits (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  itr_pkg::req_t    req,
	output logic             dig_valid,
	input  wire              dig_stall,
	output itr_pkg::dig_t    dig
);

	itr_pkg::state_t               state_q, state_nxt;
	logic [itr_pkg::CNT_W-1:0]     count_q;
	logic [itr_pkg::RADIX_W-1:0]   radix_q;
	logic                          out_valid_q;
	itr_pkg::dig_t                 out_q;

	itr_pkg::div_cmd_t             div_cmd;
	itr_pkg::div_res_t             div_res;
	logic [itr_pkg::RADIX_W-1:0]   rd_data;

	logic                          accept;
	logic                          is_zero;
	logic                          slot_free;
	logic                          mem_we;
	logic                          mem_re;
	logic                          emit;
	logic [itr_pkg::CNT_W-1:0]     count_dec;

	assign is_zero   = req.number == '0;
	assign slot_free = !out_valid_q || !dig_stall;
	assign count_dec = count_q - itr_pkg::CNT_W'(1);

	itr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.res    (div_res)
	);

	itr_stack u_stack (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (count_q[itr_pkg::ADDR_W-1:0]),
		.wdata   (div_res.remainder),
		.re      (mem_re),
		.raddr   (count_dec[itr_pkg::ADDR_W-1:0]),
		.rdata_q (rd_data)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itr_pkg::ST_IDLE: begin
				if (accept && !is_zero) state_nxt = itr_pkg::ST_DIV;
			end
			itr_pkg::ST_DIV: begin
				if (div_res.done && div_res.quotient == '0) state_nxt = itr_pkg::ST_READ;
			end
			itr_pkg::ST_READ: begin
				state_nxt = itr_pkg::ST_EMIT;
			end
			itr_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_nxt = (count_q == itr_pkg::CNT_W'(1)) ? itr_pkg::ST_IDLE
					                                            : itr_pkg::ST_READ;
				end
			end
			default: state_nxt = itr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall        = 1'b1;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		emit             = 1'b0;
		div_cmd.start    = 1'b0;
		div_cmd.dividend = req.number;
		div_cmd.divisor  = itr_pkg::clamp_radix(req.radix);
		unique case (state_q)
			itr_pkg::ST_IDLE: begin
				req_stall     = out_valid_q;
				div_cmd.start = req_valid && !out_valid_q && !is_zero;
			end
			itr_pkg::ST_DIV: begin
				mem_we           = div_res.done;
				div_cmd.start    = div_res.done && div_res.quotient != '0;
				div_cmd.dividend = div_res.quotient;
				div_cmd.divisor  = radix_q;
			end
			itr_pkg::ST_READ: begin
				mem_re = 1'b1;
			end
			itr_pkg::ST_EMIT: begin
				emit = slot_free;
			end
			default: ;
		endcase
	end

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itr_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				count_q <= '0;
			end else if (mem_we) begin
				count_q <= count_q + itr_pkg::CNT_W'(1);
			end else if (emit) begin
				count_q <= count_dec;
			end
			if ((accept && is_zero) || emit) begin
				out_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) radix_q <= itr_pkg::clamp_radix(req.radix);
		if (accept && is_zero) begin
			out_q.digit_char <= '0;
			out_q.last       <= 1'b1;
			out_q.empty_res  <= 1'b1;
		end else if (emit) begin
			out_q.digit_char <= itr_pkg::to_ascii(rd_data);
			out_q.last       <= count_q == itr_pkg::CNT_W'(1);
			out_q.empty_res  <= 1'b0;
		end
	end

	assign dig_valid = out_valid_q;
	assign dig       = out_q;

endmodule
`default_nettype wire

>>> design/itr_div.sv
`default_nettype none
// Restoring divider: one quotient bit per cycle, dividend shifts out as quotient shifts in.
module itr_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  itr_pkg::div_cmd_t     cmd,
	output itr_pkg::div_res_t     res
);

	logic                          busy_q;
	logic                          done_q;
	logic [itr_pkg::STEP_W-1:0]    step_q;
	logic [itr_pkg::NUM_W-1:0]     quo_q;
	logic [itr_pkg::RADIX_W-1:0]   rem_q;
	logic [itr_pkg::RADIX_W-1:0]   div_q;

	logic [itr_pkg::RADIX_W:0]     trial;
	logic                          ge;
	logic [itr_pkg::RADIX_W:0]     diff;

	assign trial = {rem_q, quo_q[itr_pkg::NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == itr_pkg::STEP_W'(itr_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + itr_pkg::STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			div_q <= cmd.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[itr_pkg::NUM_W-2:0], ge};
			rem_q <= ge ? diff[itr_pkg::RADIX_W-1:0] : trial[itr_pkg::RADIX_W-1:0];
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule
`default_nettype wire

>>> design/itr_stack.sv
`default_nettype none
module itr_stack (
	input  wire                          clk,
	input  wire                          we,
	input  wire [itr_pkg::ADDR_W-1:0]    waddr,
	input  wire [itr_pkg::RADIX_W-1:0]   wdata,
	input  wire                          re,
	input  wire [itr_pkg::ADDR_W-1:0]    raddr,
	output logic [itr_pkg::RADIX_W-1:0]  rdata_q
);

	logic [itr_pkg::RADIX_W-1:0] mem_q [itr_pkg::MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[raddr];
	end

endmodule
`default_nettype wire
